/* src/uart_16550_register_model_defines.svh */
// ----------------------------------------------------------------------------
// UART 16550 register model: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UART_16550_REGISTER_MODEL_DEFINES_SVH
`define UART_16550_REGISTER_MODEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UART16_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uart16 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UART16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uart16 assertion failed");

`endif

/* src/uart16_pkg.sv */
// ----------------------------------------------------------------------------
// UART 16550 register model package
// Beat types, function codes, register offsets and bit constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uart16_pkg;

  localparam int unsigned RX_DEPTH_DEFAULT = 256;

  localparam logic [1:0] FUNC_READ      = 2'd0;
  localparam logic [1:0] FUNC_WRITE     = 2'd1;
  localparam logic [1:0] FUNC_HOST_BYTE = 2'd2;

  localparam logic [7:0] REG_DATA = 8'd0;
  localparam logic [7:0] REG_IER  = 8'd1;
  localparam logic [7:0] REG_IIR  = 8'd2;
  localparam logic [7:0] REG_LCR  = 8'd3;
  localparam logic [7:0] REG_MCR  = 8'd4;
  localparam logic [7:0] REG_LSR  = 8'd5;
  localparam logic [7:0] REG_MSR  = 8'd6;
  localparam logic [7:0] REG_SCR  = 8'd7;

  localparam logic [3:0] SIZE_BYTE = 4'd1;

  localparam logic [7:0] ESC_BYTE     = 8'h01;
  localparam logic [7:0] QUIT_BYTE    = 8'h78;
  localparam logic [7:0] IER_MASK     = 8'h0f;
  localparam logic [7:0] IIR_FIFO_ON  = 8'hc0;
  localparam logic [7:0] IIR_RX_DATA  = 8'h04;
  localparam logic [7:0] IIR_THR_EMPT = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;
  localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
  localparam logic [7:0] MSR_VALUE    = 8'hb0;
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned FCR_CLR_BIT  = 1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_offset;
    logic [3:0] bus_size;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       quit_request;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] push_data;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } fifo_status_t;

endpackage

/* src/uart16_fifo.sv */
// ----------------------------------------------------------------------------
// UART 16550 receive FIFO
// Circular byte store with a registered head read that is prefetched from
// the next read pointer, with a bypass for a byte written in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uart_16550_register_model_defines.svh"

module uart16_fifo
  import uart16_pkg::*;
#(
  parameter int unsigned RxDepth = RX_DEPTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fifo_ctrl_t   ctrl_i,
  output fifo_status_t status_o,
  output logic [7:0]   head_o
);

  localparam int unsigned PtrW = $clog2(RxDepth);
  localparam int unsigned CntW = $clog2(RxDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RxDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(RxDepth);

  logic [7:0]      mem [RxDepth];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      mem_rd_q;
  logic            byp_q;
  logic [7:0]      byp_data_q;
  logic            do_push, do_pop;

  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == CntFull);
  assign status_o.single = (count_q == CntW'(1));

  assign do_push = ctrl_i.push && !status_o.full && !ctrl_i.clear;
  assign do_pop  = ctrl_i.pop && !status_o.empty && !ctrl_i.clear;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (ctrl_i.clear) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      count_d  = '0;
    end else begin
      if (do_push) begin
        wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_d = count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      byp_q    <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      byp_q    <= do_push && (wr_ptr_q == rd_ptr_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= ctrl_i.push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q   <= mem[rd_ptr_d];
    byp_data_q <= ctrl_i.push_data;
  end

  assign head_o = byp_q ? byp_data_q : mem_rd_q;

  `UART16_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntFull)
  `UART16_ASSERT_SAME(a_empty_ptrs, clk_i, rst_ni, count_q == '0, rd_ptr_q == wr_ptr_q)
  `UART16_ASSERT_SAME(a_full_ptrs, clk_i, rst_ni, count_q == CntFull, rd_ptr_q == wr_ptr_q)
  `UART16_ASSERT_NEXT(a_clear, clk_i, rst_ni, ctrl_i.clear, count_q == '0)

endmodule

/* src/uart16_core.sv */
// ----------------------------------------------------------------------------
// UART 16550 register file and decode
// Holds the control registers and the escape filter, decodes one beat and
// forms its result and the receive FIFO requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart16_core
  import uart16_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  in_item_t     item_i,
  input  logic [7:0]   head_i,
  input  fifo_status_t fifo_status_i,
  output fifo_ctrl_t   fifo_ctrl_o,
  output out_item_t    result_o
);

  logic [3:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic       esc_q, esc_d;
  logic       dlab;
  logic       is_read, is_write, is_host;
  logic       nonempty_after;
  logic [7:0] iir_val;

  assign dlab     = lcr_q[LCR_DLAB_BIT];
  assign is_read  = item_valid_i && (item_i.func == FUNC_READ);
  assign is_write = item_valid_i && (item_i.func == FUNC_WRITE)
                    && (item_i.bus_size == SIZE_BYTE);
  assign is_host  = item_valid_i && (item_i.func == FUNC_HOST_BYTE);

  always_comb begin
    if (ier_q[0] && !fifo_status_i.empty) begin
      iir_val = IIR_FIFO_ON | IIR_RX_DATA;
    end else if (ier_q[1]) begin
      iir_val = IIR_FIFO_ON | IIR_THR_EMPT;
    end else begin
      iir_val = IIR_FIFO_ON | IIR_NONE;
    end
  end

  always_comb begin
    ier_d = ier_q;
    lcr_d = lcr_q;
    mcr_d = mcr_q;
    scr_d = scr_q;
    dll_d = dll_q;
    dlm_d = dlm_q;
    esc_d = esc_q;
    fifo_ctrl_o = '0;
    result_o = '0;

    if (is_read) begin
      unique case (item_i.reg_offset)
        REG_DATA: begin
          if (dlab) begin
            result_o.read_data = dll_q;
          end else if (!fifo_status_i.empty) begin
            result_o.read_data = head_i;
            fifo_ctrl_o.pop    = 1'b1;
          end
        end
        REG_IER: result_o.read_data = dlab ? dlm_q : {4'b0, ier_q};
        REG_IIR: result_o.read_data = iir_val;
        REG_LCR: result_o.read_data = lcr_q;
        REG_MCR: result_o.read_data = mcr_q;
        REG_LSR: result_o.read_data = LSR_TX_EMPTY | {7'b0, !fifo_status_i.empty};
        REG_MSR: result_o.read_data = MSR_VALUE;
        REG_SCR: result_o.read_data = scr_q;
        default: result_o.read_data = 8'h00;
      endcase
    end

    if (is_write) begin
      unique case (item_i.reg_offset)
        REG_DATA: begin
          if (dlab) begin
            dll_d = item_i.write_data;
          end else begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = item_i.write_data;
          end
        end
        REG_IER: begin
          if (dlab) begin
            dlm_d = item_i.write_data;
          end else begin
            ier_d = 4'(item_i.write_data & IER_MASK);
          end
        end
        REG_IIR: fifo_ctrl_o.clear = item_i.write_data[FCR_CLR_BIT];
        REG_LCR: lcr_d = item_i.write_data;
        REG_MCR: mcr_d = item_i.write_data;
        REG_SCR: scr_d = item_i.write_data;
        default: ;
      endcase
    end

    if (is_host) begin
      fifo_ctrl_o.push_data = item_i.rx_byte;
      if (esc_q) begin
        esc_d = 1'b0;
        if (item_i.rx_byte == QUIT_BYTE) begin
          result_o.quit_request = 1'b1;
        end else begin
          fifo_ctrl_o.push = 1'b1;
        end
      end else if (item_i.rx_byte == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        fifo_ctrl_o.push = 1'b1;
      end
    end

    priority if (fifo_ctrl_o.clear) begin
      nonempty_after = 1'b0;
    end else if (fifo_ctrl_o.push) begin
      nonempty_after = 1'b1;
    end else if (fifo_ctrl_o.pop) begin
      nonempty_after = !fifo_status_i.single;
    end else begin
      nonempty_after = !fifo_status_i.empty;
    end

    result_o.irq = (ier_d[0] && nonempty_after) || ier_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ier_q <= '0;
      lcr_q <= '0;
      mcr_q <= '0;
      scr_q <= '0;
      dll_q <= 8'd3;
      dlm_q <= '0;
      esc_q <= 1'b0;
    end else begin
      ier_q <= ier_d;
      lcr_q <= lcr_d;
      mcr_q <= mcr_d;
      scr_q <= scr_d;
      dll_q <= dll_d;
      dlm_q <= dlm_d;
      esc_q <= esc_d;
    end
  end

endmodule

/* src/uart_16550_register_model.sv */
// ----------------------------------------------------------------------------
// UART 16550 register model
// Bus reads, bus writes and host bytes go through a 16550A-style register
// file with a receive FIFO; each beat gives one result beat.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    in_item_i  (in_item_t)
//   output    out_valid_o / out_ready_i  out_item_o (out_item_t)
//
// One beat is taken per cycle while the output is not stalled; a beat passes
// the input register, then the result register. The FIFO head is prefetched.
// The input register refills while the result register is taken.
// An output stall holds both registers once they are full.
// After reset the input is ready at once; the FIFO is not swept.
`timescale 1ns / 1ps

module uart_16550_register_model
  import uart16_pkg::*;
#(
  parameter int unsigned RxDepth = RX_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic         in_valid_q;
  in_item_t     in_item_q;
  logic         out_valid_q;
  out_item_t    out_item_q;
  logic         advance;
  logic         process;
  fifo_ctrl_t   fifo_ctrl;
  fifo_status_t fifo_status;
  logic [7:0]   fifo_head;
  out_item_t    result;

  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  uart16_fifo #(
    .RxDepth (RxDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fifo_ctrl),
    .status_o (fifo_status),
    .head_o   (fifo_head)
  );

  uart16_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (process),
    .item_i        (in_item_q),
    .head_i        (fifo_head),
    .fifo_status_i (fifo_status),
    .fifo_ctrl_o   (fifo_ctrl),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (process) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// UART 16550 register model testbench
// Walks a short table of directed beats, then well-formed register and host byte
// sequences mixed with noise, under three idling regimes and one long output
// hold-off. Each result is compared with a typed row or a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import uart16_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RX_DEPTH = RX_DEPTH_DEFAULT;
  localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
  localparam int unsigned DIR_ROWS = 27;
  localparam int unsigned BEAT_TARGET = 2000;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  out_item_t   want_q[$];
  dir_row_t    dir_tab[DIR_ROWS];
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned stall_left = 0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;

  logic [3:0]          ier_q;
  logic [7:0]          lcr_q;
  logic [7:0]          mcr_q;
  logic [7:0]          scr_q;
  logic [7:0]          dll_q;
  logic [7:0]          dlm_q;
  logic [7:0]          rx_mem[RX_DEPTH];
  logic [RX_PTR_W-1:0] rx_rd;
  logic [RX_PTR_W-1:0] rx_wr;
  int unsigned         rx_cnt;
  bit                  esc_armed;

  uart_16550_register_model u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_item_t mk_in(logic [1:0] func, logic [7:0] off, logic [3:0] size,
                                     logic [7:0] wd, logic [7:0] rb);
    in_item_t it;
    it.func        = func;
    it.reg_offset  = off;
    it.bus_size    = size;
    it.write_data  = wd;
    it.rx_byte     = rb;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic [7:0] rd, logic irq, logic txv, logic [7:0] txb,
                                       logic quit);
    out_item_t r;
    r.read_data    = rd;
    r.irq          = irq;
    r.tx_valid     = txv;
    r.tx_byte      = txb;
    r.quit_request = quit;
    return r;
  endfunction

  function automatic logic [RX_PTR_W-1:0] rx_next(logic [RX_PTR_W-1:0] p);
    return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void rx_push(logic [7:0] b);
    if (rx_cnt < RX_DEPTH) begin
      rx_mem[rx_wr] = b;
      rx_wr = rx_next(rx_wr);
      rx_cnt++;
    end
  endfunction

  function automatic logic [7:0] rx_pop();
    logic [7:0] b;
    if (rx_cnt == 0) return 8'h00;
    b = rx_mem[rx_rd];
    rx_rd = rx_next(rx_rd);
    rx_cnt--;
    return b;
  endfunction

  function automatic out_item_t uart_predict(in_item_t it);
    out_item_t r;
    logic      dlab;
    r = '0;
    dlab = lcr_q[LCR_DLAB_BIT];
    case (it.func)
      FUNC_READ: begin
        case (it.reg_offset)
          REG_DATA: r.read_data = dlab ? dll_q : rx_pop();
          REG_IER:  r.read_data = dlab ? dlm_q : {4'b0, ier_q};
          REG_IIR: begin
            if (ier_q[0] && rx_cnt != 0) r.read_data = IIR_FIFO_ON | IIR_RX_DATA;
            else if (ier_q[1]) r.read_data = IIR_FIFO_ON | IIR_THR_EMPT;
            else r.read_data = IIR_FIFO_ON | IIR_NONE;
          end
          REG_LCR:  r.read_data = lcr_q;
          REG_MCR:  r.read_data = mcr_q;
          REG_LSR:  r.read_data = LSR_TX_EMPTY | {7'b0, rx_cnt != 0};
          REG_MSR:  r.read_data = MSR_VALUE;
          REG_SCR:  r.read_data = scr_q;
          default:  r.read_data = 8'h00;
        endcase
      end
      FUNC_WRITE: begin
        if (it.bus_size == SIZE_BYTE) begin
          case (it.reg_offset)
            REG_DATA: begin
              if (dlab) dll_q = it.write_data;
              else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = it.write_data;
              end
            end
            REG_IER: begin
              if (dlab) dlm_q = it.write_data;
              else ier_q = it.write_data[3:0];
            end
            REG_IIR: begin
              if (it.write_data[FCR_CLR_BIT]) begin
                rx_rd  = '0;
                rx_wr  = '0;
                rx_cnt = 0;
              end
            end
            REG_LCR: lcr_q = it.write_data;
            REG_MCR: mcr_q = it.write_data;
            REG_SCR: scr_q = it.write_data;
            default: ;
          endcase
        end
      end
      FUNC_HOST_BYTE: begin
        if (esc_armed) begin
          esc_armed = 1'b0;
          if (it.rx_byte == QUIT_BYTE) r.quit_request = 1'b1;
          else rx_push(it.rx_byte);
        end else if (it.rx_byte == ESC_BYTE) begin
          esc_armed = 1'b1;
        end else begin
          rx_push(it.rx_byte);
        end
      end
      default: ;
    endcase
    r.irq = (ier_q[0] && rx_cnt != 0) || ier_q[1];
    return r;
  endfunction

  function automatic logic [3:0] any_size();
    return 4'($urandom_range(15));
  endfunction

  function automatic in_item_t host_item(logic [7:0] b);
    return mk_in(FUNC_HOST_BYTE, 8'($urandom_range(255)), any_size(),
                 8'($urandom_range(255)), b);
  endfunction

  function automatic in_item_t rd_item(logic [7:0] off);
    return mk_in(FUNC_READ, off, any_size(), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
  endfunction

  function automatic in_item_t wr_item(logic [7:0] off, logic [7:0] d);
    return mk_in(FUNC_WRITE, off, SIZE_BYTE, d, 8'($urandom_range(255)));
  endfunction

  function automatic in_item_t noise_item();
    in_item_t    it;
    int unsigned pick;
    it = mk_in(FUNC_UNUSED, 8'($urandom_range(255)), any_size(), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 35) it.func = FUNC_HOST_BYTE;
    else if (pick < 65) it.func = FUNC_READ;
    else if (pick < 95) it.func = FUNC_WRITE;
    if ($urandom_range(9) < 8) it.reg_offset = 8'($urandom_range(7));
    if ($urandom_range(3) != 0) it.bus_size = SIZE_BYTE;
    pick = $urandom_range(99);
    if (pick < 10) it.rx_byte = ESC_BYTE;
    else if (pick < 15) it.rx_byte = QUIT_BYTE;
    return it;
  endfunction

  task automatic send_beat(in_item_t it, logic typed = 1'b0, out_item_t want = '0);
    out_item_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = uart_predict(it);
    want_q.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_beat(noise_item());
    end else if (pick < 60) begin
      n = $urandom_range(8, 1);
      repeat (n) send_beat(host_item(8'($urandom_range(255))));
      repeat (n) send_beat(rd_item(REG_DATA));
    end else if (pick < 70) begin
      send_beat(host_item(ESC_BYTE));
      n = $urandom_range(2);
      send_beat(host_item(n == 0 ? QUIT_BYTE : n == 1 ? ESC_BYTE : 8'($urandom_range(255))));
    end else if (pick < 80) begin
      send_beat(wr_item(REG_LCR, {1'b1, 7'($urandom_range(127))}));
      send_beat(wr_item(REG_DATA, 8'($urandom_range(255))));
      send_beat(wr_item(REG_IER, 8'($urandom_range(255))));
      send_beat(rd_item(REG_DATA));
      send_beat(rd_item(REG_IER));
      send_beat(wr_item(REG_LCR, {1'b0, 7'($urandom_range(127))}));
    end else if (pick < 90) begin
      send_beat(wr_item(REG_IER, 8'($urandom_range(255))));
      send_beat(rd_item(REG_IIR));
      send_beat(rd_item(REG_LSR));
    end else begin
      send_beat(wr_item(REG_IIR, 8'($urandom_range(255))));
      send_beat(rd_item(REG_LSR));
      send_beat(rd_item(REG_DATA));
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req && !stall_done) begin
      out_ready  <= 1'b0;
      stall_left <= 400;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result beat");
        mismatches++;
      end else begin
        want = want_q.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, out_item.read_data);
          mismatches++;
        end
        if (out_item.irq !== want.irq) begin
          $error("irq: expected %0h, got %0h", want.irq, out_item.irq);
          mismatches++;
        end
        if (out_item.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %0h, got %0h", want.tx_valid, out_item.tx_valid);
          mismatches++;
        end
        if (out_item.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, out_item.tx_byte);
          mismatches++;
        end
        if (out_item.quit_request !== want.quit_request) begin
          $error("quit_request: expected %0h, got %0h", want.quit_request,
                 out_item.quit_request);
          mismatches++;
        end
      end
    end
  end

  initial begin
    ier_q     = '0;
    lcr_q     = '0;
    mcr_q     = '0;
    scr_q     = '0;
    dll_q     = 8'h03;
    dlm_q     = '0;
    rx_rd     = '0;
    rx_wr     = '0;
    rx_cnt    = 0;
    esc_armed = 1'b0;

    dir_tab[0]  = '{rd_item(REG_IIR), 1'b1,
                    mk_out(IIR_FIFO_ON | IIR_NONE, 1'b0, 1'b0, 8'h00, 1'b0)};
    dir_tab[1]  = '{rd_item(REG_LSR), 1'b1, mk_out(LSR_TX_EMPTY, 1'b0, 1'b0, 8'h00, 1'b0)};
    dir_tab[2]  = '{rd_item(REG_MSR), 1'b1, mk_out(MSR_VALUE, 1'b0, 1'b0, 8'h00, 1'b0)};
    dir_tab[3]  = '{rd_item(REG_DATA), 1'b1, mk_out(8'h00, 1'b0, 1'b0, 8'h00, 1'b0)};
    dir_tab[4]  = '{mk_in(FUNC_READ, 8'hff, 4'hf, 8'hff, 8'hff), 1'b1, '0};
    dir_tab[5]  = '{wr_item(REG_LCR, 8'h80), 1'b1, '0};
    dir_tab[6]  = '{rd_item(REG_DATA), 1'b1, mk_out(8'h03, 1'b0, 1'b0, 8'h00, 1'b0)};
    dir_tab[7]  = '{wr_item(REG_DATA, 8'hff), 1'b0, '0};
    dir_tab[8]  = '{mk_in(FUNC_WRITE, REG_DATA, 4'h0, 8'h00, 8'h00), 1'b0, '0};
    dir_tab[9]  = '{rd_item(REG_DATA), 1'b0, '0};
    dir_tab[10] = '{wr_item(REG_LCR, 8'h00), 1'b0, '0};
    dir_tab[11] = '{wr_item(REG_DATA, 8'hff), 1'b1, mk_out(8'h00, 1'b0, 1'b1, 8'hff, 1'b0)};
    dir_tab[12] = '{mk_in(FUNC_WRITE, REG_DATA, 4'h8, 8'h00, 8'h00), 1'b1, '0};
    dir_tab[13] = '{wr_item(REG_IER, 8'hff), 1'b1, mk_out(8'h00, 1'b1, 1'b0, 8'h00, 1'b0)};
    dir_tab[14] = '{rd_item(REG_IIR), 1'b1,
                    mk_out(IIR_FIFO_ON | IIR_THR_EMPT, 1'b1, 1'b0, 8'h00, 1'b0)};
    dir_tab[15] = '{wr_item(REG_IER, 8'h01), 1'b0, '0};
    dir_tab[16] = '{host_item(8'h55), 1'b0, '0};
    dir_tab[17] = '{rd_item(REG_IIR), 1'b0, '0};
    dir_tab[18] = '{host_item(ESC_BYTE), 1'b0, '0};
    dir_tab[19] = '{host_item(ESC_BYTE), 1'b0, '0};
    dir_tab[20] = '{host_item(ESC_BYTE), 1'b0, '0};
    dir_tab[21] = '{host_item(QUIT_BYTE), 1'b0, '0};
    dir_tab[22] = '{wr_item(REG_MSR, 8'h00), 1'b0, '0};
    dir_tab[23] = '{mk_in(FUNC_UNUSED, 8'hff, 4'hf, 8'hff, 8'hff), 1'b0, '0};
    dir_tab[24] = '{rd_item(REG_DATA), 1'b0, '0};
    dir_tab[25] = '{wr_item(REG_IIR, 8'(1 << FCR_CLR_BIT)), 1'b0, '0};
    dir_tab[26] = '{rd_item(REG_LSR), 1'b0, '0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    send_idle = 32;
    recv_idle = 75;
    while (beats_sent < DIR_ROWS + 650) random_sequence();

    send_idle = 75;
    recv_idle = 32;
    while (beats_sent < DIR_ROWS + 1300) random_sequence();

    send_idle = 0;
    recv_idle = 0;
    stall_req = 1'b1;
    send_beat(wr_item(REG_LCR, 8'h00));
    send_beat(wr_item(REG_IIR, 8'(1 << FCR_CLR_BIT)));
    repeat (RX_DEPTH + 12) send_beat(host_item({1'b1, 7'($urandom_range(127))}));
    send_beat(rd_item(REG_LSR));
    send_beat(wr_item(REG_IER, 8'h01));
    send_beat(rd_item(REG_IIR));
    repeat (RX_DEPTH + 4) send_beat(rd_item(REG_DATA));
    while (beats_sent < BEAT_TARGET) random_sequence();

    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
